// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRHT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/prht_pkg.sv =====
// ----------------------------------------------------------------------------
// prht_pkg
// Field widths, operation codes and bucket hash constants.
// ----------------------------------------------------------------------------
package prht_pkg;

	localparam int ADDR_W = 48;
	localparam int CNT_W  = 32;
	localparam int OP_W   = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 3'd0,
		OP_FIND     = 3'd1,
		OP_DELETE   = 3'd2,
		OP_INCREASE = 3'd3,
		OP_DECREASE = 3'd4
	} op_t;

	// The page number is folded in 12-bit chunks before the final reduction.
	localparam int HASH_CHUNK_W = 12;
	localparam int HASH_CHUNKS  = ADDR_W / HASH_CHUNK_W;
	localparam int HASH_SUM_W   = 26;
	localparam int RECIP_W      = 23;

endpackage

// ===== sv/prht_ram.sv =====
// ----------------------------------------------------------------------------
// prht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module prht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/prht_bucket_hash.sv =====
// ----------------------------------------------------------------------------
// prht_bucket_hash
// Bucket index: (phys_address >> PAGE_SHIFT) mod BUCKETS.
// A power-of-two bucket count is a plain combinational mask. Any other
// count goes through a three-stage fold, reciprocal multiply and correction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prht_bucket_hash #(
	parameter int BUCKETS    = 256,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [prht_pkg::ADDR_W-1:0] phys_address,
	output logic                       bucket_valid,
	output logic [$clog2(BUCKETS)-1:0] bucket
);

	import prht_pkg::*;

	localparam int  BKT_W    = $clog2(BUCKETS);
	localparam bit  POW2     = ((1 << BKT_W) == BUCKETS);
	localparam int  HASH_LAT = POW2 ? 0 : 3;

	logic [ADDR_W-1:0] page_num;

	assign page_num = phys_address >> PAGE_SHIFT;

	generate
		if (POW2) begin : g_mask
			assign bucket_valid = start;
			assign bucket       = page_num[BKT_W-1:0];
		end else begin : g_reduce
			// Residues of 2^(12*i) modulo the bucket count.
			localparam logic [63:0] RES0 = 64'd1 % BUCKETS;
			localparam logic [63:0] RES1 = (64'd1 << 12) % BUCKETS;
			localparam logic [63:0] RES2 = (64'd1 << 24) % BUCKETS;
			localparam logic [63:0] RES3 = (64'd1 << 36) % BUCKETS;
			localparam logic [63:0] RECIP = (64'd1 << HASH_SUM_W) / BUCKETS;
			localparam int PROD_W = HASH_SUM_W + RECIP_W;

			logic [HASH_CHUNK_W-1:0] res_c [HASH_CHUNKS];
			logic [HASH_SUM_W-1:0]   fold;
			logic [PROD_W-1:0]       recip_prod;
			logic [HASH_SUM_W+BKT_W:0] qb_prod;
			logic [HASH_SUM_W-1:0]   diff;
			logic [HASH_SUM_W-1:0]   rem;

			logic [HASH_SUM_W-1:0]   fold_s1;
			logic [HASH_SUM_W-1:0]   fold_s2;
			logic [RECIP_W-1:0]      quot_s2;
			logic [BKT_W-1:0]        bucket_s3;
			logic [2:0]              valid_q;

			assign res_c[0] = RES0[HASH_CHUNK_W-1:0];
			assign res_c[1] = RES1[HASH_CHUNK_W-1:0];
			assign res_c[2] = RES2[HASH_CHUNK_W-1:0];
			assign res_c[3] = RES3[HASH_CHUNK_W-1:0];

			// Stage 1: sum of chunk times residue stays congruent and under 2^26.
			always_comb begin
				fold = '0;
				for (int i = 0; i < HASH_CHUNKS; i++) begin
					fold = fold + HASH_SUM_W'(page_num[i*HASH_CHUNK_W +: HASH_CHUNK_W]
						* res_c[i]);
				end
			end

			// Stage 2 estimates the quotient low by at most one.
			assign recip_prod = PROD_W'(fold_s1) * PROD_W'(RECIP[RECIP_W-1:0]);

			// Stage 3: remainder below twice the bucket count, one correction.
			assign qb_prod = (HASH_SUM_W+BKT_W+1)'(quot_s2)
				* (HASH_SUM_W+BKT_W+1)'(BUCKETS);
			assign diff    = fold_s2 - qb_prod[HASH_SUM_W-1:0];
			assign rem     = (diff >= HASH_SUM_W'(BUCKETS)) ? diff - HASH_SUM_W'(BUCKETS) : diff;

			always_ff @(posedge clk) begin
				fold_s1   <= fold;
				fold_s2   <= fold_s1;
				quot_s2   <= recip_prod[PROD_W-1:HASH_SUM_W];
				bucket_s3 <= rem[BKT_W-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q <= '0;
				end else begin
					valid_q <= {valid_q[1:0], start};
				end
			end

			assign bucket_valid = valid_q[2];
			assign bucket       = bucket_s3;
		end
	endgenerate

	`PRHT_ASSERT_SAME(a_hash_latency, start, ##HASH_LAT bucket_valid,
		"bucket index did not arrive at the fixed hash latency")

endmodule

// ===== sv/page_refcount_hash_table.sv =====
// ----------------------------------------------------------------------------
// page_refcount_hash_table
// Reference counts keyed by physical address, held in a bucketed row memory.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries operation, phys_address and
// start_count; the output channel (out_valid/out_ready) returns ref_count,
// hit and status, exactly one result transaction per input transaction, in
// order. One item is in flight at a time. Each bucket is one memory row that
// is read once and written back once per item.
// With a power-of-two BUCKETS the bucket index is combinational and the row
// is read at acceptance; any other bucket count first passes through the
// modulo reduction. A new item is accepted only after the last one commits.
// After reset the block clears every row, one per cycle, and in_ready stays
// low during that pass.
// A result waits in the output register while out_ready is low. The next
// item may be accepted meanwhile, and its row write-back waits until the
// output register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_refcount_hash_table #(
	parameter int BUCKETS    = 256,
	parameter int WAYS       = 4,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [prht_pkg::OP_W-1:0]          operation,
	input  logic [prht_pkg::ADDR_W-1:0]        phys_address,
	input  logic signed [prht_pkg::CNT_W-1:0]  start_count,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [prht_pkg::CNT_W-1:0]  ref_count,
	output logic                               hit,
	output logic                               status
);

	import prht_pkg::*;

	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int KEY_OFS = WAYS;
	localparam int CNT_OFS = WAYS + WAYS * ADDR_W;
	localparam int ROW_W   = WAYS * (1 + ADDR_W + CNT_W);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_LOOKUP
	} state_t;

	state_t            state_q;
	logic [BKT_W-1:0]  clr_addr_q;
	logic [BKT_W-1:0]  bucket_q;
	op_t               op_q;
	logic [ADDR_W-1:0] key_q;
	logic [CNT_W-1:0]  start_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  ref_count_q;
	logic              hit_q;
	logic              status_q;

	logic              accept;
	logic              commit;
	logic              h_valid;
	logic [BKT_W-1:0]  h_bucket;

	logic              wr_en;
	logic [BKT_W-1:0]  wr_addr;
	logic [ROW_W-1:0]  wr_data;
	logic [ROW_W-1:0]  rd_data;
	logic [ROW_W-1:0]  row_next;
	logic [WAYS-1:0]   wr_vld_bits;

	// Row fields and update.
	logic [WAYS-1:0]   vld, match, first, upto, slot;
	logic [ADDR_W-1:0] key_w [WAYS];
	logic [CNT_W-1:0]  cnt_w [WAYS];
	logic [WAYS-1:0]   rm_vld, n_vld;
	logic [ADDR_W-1:0] rm_key [WAYS];
	logic [ADDR_W-1:0] n_key [WAYS];
	logic [CNT_W-1:0]  rm_cnt [WAYS];
	logic [CNT_W-1:0]  n_cnt [WAYS];
	logic              seen, prev_vld, full;
	logic [CNT_W-1:0]  sel_cnt, cnt_inc, cnt_dec, rc_d;
	logic              hit_d, status_d;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready);

	prht_bucket_hash #(
		.BUCKETS    (BUCKETS),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_hash (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.phys_address (phys_address),
		.bucket_valid (h_valid),
		.bucket       (h_bucket)
	);

	prht_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_rows (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (h_valid),
		.rd_addr (h_bucket),
		.rd_data (rd_data)
	);

	// Unpack the row and locate the first match and the first free way.
	always_comb begin
		seen     = 1'b0;
		prev_vld = 1'b1;
		sel_cnt  = '0;
		for (int i = 0; i < WAYS; i++) begin
			vld[i]   = rd_data[i];
			key_w[i] = rd_data[KEY_OFS + i*ADDR_W +: ADDR_W];
			cnt_w[i] = rd_data[CNT_OFS + i*CNT_W +: CNT_W];
			match[i] = vld[i] && (key_w[i] == key_q);
			first[i] = match[i] && !seen;
			seen     = seen || match[i];
			upto[i]  = seen;
			slot[i]  = !vld[i] && prev_vld;
			prev_vld = vld[i];
			if (first[i]) begin
				sel_cnt = cnt_w[i];
			end
		end
		full    = vld[WAYS-1];
		cnt_inc = sel_cnt + CNT_W'(1);
		cnt_dec = sel_cnt - CNT_W'(1);
	end

	// Removal: every way from the first match on takes its upper neighbor.
	always_comb begin
		for (int i = 0; i < WAYS - 1; i++) begin
			rm_vld[i] = upto[i] ? vld[i+1]   : vld[i];
			rm_key[i] = upto[i] ? key_w[i+1] : key_w[i];
			rm_cnt[i] = upto[i] ? cnt_w[i+1] : cnt_w[i];
		end
		rm_vld[WAYS-1] = upto[WAYS-1] ? 1'b0 : vld[WAYS-1];
		rm_key[WAYS-1] = key_w[WAYS-1];
		rm_cnt[WAYS-1] = cnt_w[WAYS-1];
	end

	always_comb begin
		n_vld    = vld;
		n_key    = key_w;
		n_cnt    = cnt_w;
		rc_d     = '0;
		hit_d    = seen;
		status_d = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				if (full) begin
					status_d = 1'b1;
				end else begin
					for (int i = 0; i < WAYS; i++) begin
						if (slot[i]) begin
							n_vld[i] = 1'b1;
							n_key[i] = key_q;
							n_cnt[i] = start_q;
						end
					end
				end
			end
			OP_FIND: begin
				if (seen) begin
					rc_d = sel_cnt;
				end
			end
			OP_DELETE: begin
				if (seen) begin
					n_vld = rm_vld;
					n_key = rm_key;
					n_cnt = rm_cnt;
				end
			end
			OP_INCREASE: begin
				if (seen) begin
					rc_d = cnt_inc;
					for (int i = 0; i < WAYS; i++) begin
						if (first[i]) begin
							n_cnt[i] = cnt_inc;
						end
					end
				end else if (!full) begin
					rc_d = CNT_W'(1);
					for (int i = 0; i < WAYS; i++) begin
						if (slot[i]) begin
							n_vld[i] = 1'b1;
							n_key[i] = key_q;
							n_cnt[i] = CNT_W'(1);
						end
					end
				end else begin
					status_d = 1'b1;
				end
			end
			OP_DECREASE: begin
				if (seen) begin
					rc_d = cnt_dec;
					if (cnt_dec == '0) begin
						n_vld = rm_vld;
						n_key = rm_key;
						n_cnt = rm_cnt;
					end else begin
						for (int i = 0; i < WAYS; i++) begin
							if (first[i]) begin
								n_cnt[i] = cnt_dec;
							end
						end
					end
				end
			end
			default: begin
				hit_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			row_next[i]                            = n_vld[i];
			row_next[KEY_OFS + i*ADDR_W +: ADDR_W] = n_key[i];
			row_next[CNT_OFS + i*CNT_W +: CNT_W]   = n_cnt[i];
		end
	end

	// The clearing pass owns the write port until it finishes.
	assign wr_en       = (state_q == ST_CLEAR) || commit;
	assign wr_addr     = (state_q == ST_CLEAR) ? clr_addr_q : bucket_q;
	assign wr_data     = (state_q == ST_CLEAR) ? '0 : row_next;
	assign wr_vld_bits = wr_data[WAYS-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(operation);
			key_q   <= phys_address;
			start_q <= $unsigned(start_count);
		end
		if (h_valid) begin
			bucket_q <= h_bucket;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			ref_count_q <= '0;
			hit_q       <= 1'b0;
			status_q    <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_addr_q <= clr_addr_q + BKT_W'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= h_valid ? ST_LOOKUP : ST_HASH;
					end
				end
				ST_HASH: begin
					if (h_valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (commit) begin
						state_q     <= ST_IDLE;
						ref_count_q <= rc_d;
						hit_q       <= hit_d;
						status_q    <= status_d;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign ref_count = $signed(ref_count_q);
	assign hit       = hit_q;
	assign status    = status_q;

	`PRHT_ASSERT_SAME(a_hash_in_window, h_valid,
		(state_q == ST_IDLE) || (state_q == ST_HASH),
		"bucket index arrived outside an accepted transaction")
	`PRHT_ASSERT_NEXT(a_read_then_lookup, h_valid, state_q == ST_LOOKUP,
		"row read was not followed by the lookup cycle")
	`PRHT_ASSERT_SAME(a_row_packed, wr_en,
		(wr_vld_bits & (wr_vld_bits + WAYS'(1))) == '0,
		"written row has a gap among its valid ways")
	`PRHT_ASSERT_SAME(a_status_insert_only, commit && status_d,
		(op_q == OP_ADD) || (op_q == OP_INCREASE),
		"full-bucket status raised by an operation that does not insert")
	`PRHT_ASSERT_NEXT(a_commit_output, commit, out_valid_q,
		"committed result did not reach the output register")

endmodule
